// File: hw/rtl/sfs_pkg.sv
// shared types and codes for the sprite frame sequencer
package sfs_pkg;

  // input operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_WRITE = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_FRAME_COUNT   = 2'd0;
  localparam logic [1:0] CFG_FRAME_WIDTH   = 2'd1;
  localparam logic [1:0] CFG_FRAME_HEIGHT  = 2'd2;
  localparam logic [1:0] CFG_SHEET_COLUMNS = 2'd3;

  // saturation limit of the elapsed counter
  localparam logic [24:0] ELAPSED_MAX = 25'h1FF_FFFF;

  // one frame table entry
  typedef struct packed {
    logic [15:0] pause_time;
    logic [15:0] show_time;
  } entry_t;

  // one result
  typedef struct packed {
    logic [7:0]  frame_index;
    logic [19:0] origin_x;
    logic [19:0] origin_y;
    logic        visible;
    logic        running;
    logic        advanced;
    logic        write_rejected;
  } res_t;

endpackage

// File: hw/rtl/sprite_frame_sequencer.sv
// sprite frame sequencer: frame table memory, timing state and result queue
// Each result is registered: in the output register, or in the skid register while the output is stalled.
// Throughput: one request per cycle while the skid register is empty; the frame table is read every cycle at
// the frame that becomes current, so its read latency is hidden.
// A two-entry result queue accepts one more request while a result is stalled.
// Reset is synchronous and clears all control state; the frame table is not
// cleared and holds undefined data until written, so no clearing pass runs.
module sprite_frame_sequencer #(
  parameter int MAX_FRAMES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  // requests
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_tick_delta,
  input  logic [7:0]  in_entry_index,
  input  logic [15:0] in_show_time,
  input  logic [15:0] in_pause_time,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_frame_index,
  output logic [19:0] out_origin_x,
  output logic [19:0] out_origin_y,
  output logic        out_visible,
  output logic        out_running,
  output logic        out_advanced,
  output logic        out_write_rejected
);
  import sfs_pkg::*;

  // table depth is bounded by the 8-bit entry index
  localparam int         DEPTH   = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;
  localparam int         AW      = $clog2(DEPTH);
  localparam logic [8:0] DEPTH_W = 9'(DEPTH);

  // configuration registers
  logic [8:0]  frame_count_r;
  logic [11:0] frame_width_r;
  logic [11:0] frame_height_r;
  logic [8:0]  sheet_columns_r;

  // sequencer state
  logic [7:0]  cur_frame_r, cur_frame_nxt;
  logic [7:0]  col_pos_r, col_pos_nxt;
  logic [19:0] x_origin_r, x_origin_nxt;
  logic [19:0] y_origin_r, y_origin_nxt;
  logic [24:0] elapsed_r, elapsed_nxt;
  logic [15:0] interval_r, interval_nxt;
  logic        pend_r, pend_nxt;
  logic        pausing_r, pausing_nxt;
  logic        animating_r, animating_nxt;

  // frame table and its read path
  entry_t      frame_mem [DEPTH];
  entry_t      mem_q_r;
  entry_t      byp_data_r;
  logic        byp_hit_r;
  entry_t      cur_entry;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  // result queue
  res_t        res;
  res_t        out_r;
  res_t        skid_r;
  logic        out_valid_r;
  logic        skid_valid_r;
  logic        acc;
  logic        pop;

  // datapath helpers
  logic [8:0]  fc_lim;
  logic [8:0]  cols_lim;
  logic [15:0] interval_eff;
  logic [25:0] e_sum;
  logic [24:0] e_sat;
  logic        expire;
  logic [8:0]  nxt_frame;
  logic [8:0]  nxt_col;
  logic        adv;
  logic        rej;

  assign cfg_ready = 1'b1;
  assign acc       = in_valid && in_ready;
  assign pop       = out_valid_r && out_ready;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r   <= 9'd1;
      frame_width_r   <= 12'd16;
      frame_height_r  <= 12'd16;
      sheet_columns_r <= 9'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_COUNT:   frame_count_r   <= cfg_data[8:0];
        CFG_FRAME_WIDTH:   frame_width_r   <= cfg_data;
        CFG_FRAME_HEIGHT:  frame_height_r  <= cfg_data;
        CFG_SHEET_COLUMNS: sheet_columns_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // limited frame count and column count
  always_comb begin
    if (frame_count_r == 9'd0) begin
      fc_lim = 9'd1;
    end else if (frame_count_r > DEPTH_W) begin
      fc_lim = DEPTH_W;
    end else begin
      fc_lim = frame_count_r;
    end
    if (sheet_columns_r == 9'd0) begin
      cols_lim = 9'd1;
    end else if (sheet_columns_r > 9'd256) begin
      cols_lim = 9'd256;
    end else begin
      cols_lim = sheet_columns_r;
    end
  end

  // entry of the current frame, with the last write forwarded
  assign cur_entry = byp_hit_r ? byp_data_r : mem_q_r;

  // interval of a new frame arrives from the table in the cycle after the frame change
  assign interval_eff = pend_r ? cur_entry.show_time : interval_r;

  // elapsed time and expiry test
  assign e_sum  = {1'b0, elapsed_r} + 26'(in_tick_delta);
  assign e_sat  = e_sum[25] ? ELAPSED_MAX : e_sum[24:0];
  assign expire = e_sat >= {1'b0, interval_eff, 8'd0};

  assign nxt_frame = {1'b0, cur_frame_r} + 9'd1;
  assign nxt_col   = {1'b0, col_pos_r} + 9'd1;

  // request processing
  always_comb begin
    cur_frame_nxt = cur_frame_r;
    col_pos_nxt   = col_pos_r;
    x_origin_nxt  = x_origin_r;
    y_origin_nxt  = y_origin_r;
    elapsed_nxt   = elapsed_r;
    interval_nxt  = interval_eff;
    pend_nxt      = 1'b0;
    pausing_nxt   = pausing_r;
    animating_nxt = animating_r;
    adv           = 1'b0;
    rej           = 1'b0;
    wr_en         = 1'b0;
    if (acc) begin
      unique case (in_op)
        OP_TICK: begin
          if (animating_r) begin
            elapsed_nxt = e_sat;
            if (expire) begin
              elapsed_nxt = 25'd0;
              if (!pausing_r && cur_entry.pause_time != 16'd0) begin
                pausing_nxt  = 1'b1;
                interval_nxt = cur_entry.pause_time;
              end else begin
                adv         = 1'b1;
                pausing_nxt = 1'b0;
                pend_nxt    = 1'b1;
                if (nxt_frame >= fc_lim) begin
                  cur_frame_nxt = 8'd0;
                  col_pos_nxt   = 8'd0;
                  x_origin_nxt  = 20'd0;
                  y_origin_nxt  = 20'd0;
                end else begin
                  cur_frame_nxt = nxt_frame[7:0];
                  if (nxt_col >= cols_lim) begin
                    col_pos_nxt  = 8'd0;
                    x_origin_nxt = 20'd0;
                    y_origin_nxt = y_origin_r + 20'(frame_height_r);
                  end else begin
                    col_pos_nxt  = nxt_col[7:0];
                    x_origin_nxt = x_origin_r + 20'(frame_width_r);
                  end
                end
              end
            end
          end
        end
        OP_START: begin
          cur_frame_nxt = 8'd0;
          col_pos_nxt   = 8'd0;
          x_origin_nxt  = 20'd0;
          y_origin_nxt  = 20'd0;
          elapsed_nxt   = 25'd0;
          pausing_nxt   = 1'b0;
          animating_nxt = 1'b1;
          pend_nxt      = 1'b1;
        end
        OP_STOP: begin
          animating_nxt = 1'b0;
        end
        OP_WRITE: begin
          if (in_show_time == 16'd0) begin
            rej = 1'b1;
          end else if ({1'b0, in_entry_index} < DEPTH_W) begin
            wr_en = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign wr_addr = in_entry_index[AW-1:0];
  assign rd_addr = cur_frame_nxt[AW-1:0];

  // frame table memory, read every cycle at the next current frame
  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem[wr_addr] <= '{pause_time: in_pause_time, show_time: in_show_time};
    end
    mem_q_r <= frame_mem[rd_addr];
  end

  // forwarding of a write that hits the entry being read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
    end else begin
      byp_hit_r <= wr_en && (wr_addr == rd_addr);
    end
    byp_data_r <= '{pause_time: in_pause_time, show_time: in_show_time};
  end

  // sequencer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_frame_r <= 8'd0;
      col_pos_r   <= 8'd0;
      x_origin_r  <= 20'd0;
      y_origin_r  <= 20'd0;
      elapsed_r   <= 25'd0;
      interval_r  <= 16'd0;
      pend_r      <= 1'b0;
      pausing_r   <= 1'b0;
      animating_r <= 1'b0;
    end else begin
      cur_frame_r <= cur_frame_nxt;
      col_pos_r   <= col_pos_nxt;
      x_origin_r  <= x_origin_nxt;
      y_origin_r  <= y_origin_nxt;
      elapsed_r   <= elapsed_nxt;
      interval_r  <= interval_nxt;
      pend_r      <= pend_nxt;
      pausing_r   <= pausing_nxt;
      animating_r <= animating_nxt;
    end
  end

  // result of the accepted request
  assign res = '{
    frame_index:    cur_frame_nxt,
    origin_x:       x_origin_nxt,
    origin_y:       y_origin_nxt,
    visible:        !pausing_nxt,
    running:        animating_nxt,
    advanced:       adv,
    write_rejected: rej
  };

  // two-entry result queue: output register and skid register
  assign in_ready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= acc;
      end
    end else if (acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (acc) begin
        out_r <= res;
      end
    end else if (acc) begin
      skid_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_index    = out_r.frame_index;
  assign out_origin_x       = out_r.origin_x;
  assign out_origin_y       = out_r.origin_y;
  assign out_visible        = out_r.visible;
  assign out_running        = out_r.running;
  assign out_advanced       = out_r.advanced;
  assign out_write_rejected = out_r.write_rejected;

  // skid entry only holds a result behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register valid without output register");

  // a pending interval load only follows an accepted request
  a_pend_source: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> $past(acc))
    else $error("interval load pending without a frame change");

  // the first column of a row always sits at x zero
  a_col_zero_x: assert property (@(posedge clk) disable iff (!rst_n)
    (col_pos_r == 8'd0) |-> (x_origin_r == 20'd0))
    else $error("x origin not zero at first column");

  // current frame always addresses a table entry
  a_frame_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cur_frame_r} < DEPTH_W)
    else $error("current frame beyond frame table");

  // a stop request leaves the sequencer halted
  a_stop_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_op == OP_STOP) |=> !animating_r)
    else $error("sequencer still running after stop");

endmodule
